// ===== hw/rtl/flvtr_pkg.sv =====
// ============================================================================
// flvtr_pkg
// Shared types and constants for the FLV tag timestamp rebase unit.
// ============================================================================
package flvtr_pkg;

  // Byte counts of the FLV framing
  localparam int FILE_HDR_BYTES = 13;  // file header plus first previous-tag-size
  localparam int TAG_HDR_BYTES  = 11;
  localparam int TRAILER_BYTES  = 4;   // previous-tag-size after each payload
  localparam int HOLD_BYTES     = 12;  // header bytes held before the last one arrives
  localparam int CNT_W          = 25;
  localparam int IDX_W          = $clog2(FILE_HDR_BYTES);

  // Front stage codes
  localparam logic [1:0] STG_HDR_KEEP = 2'd0;
  localparam logic [1:0] STG_HDR_SKIP = 2'd1;
  localparam logic [1:0] STG_TAG_HDR  = 2'd2;
  localparam logic [1:0] STG_PAYLOAD  = 2'd3;

  // Queue entry kinds
  localparam logic [1:0] K_BYTE = 2'd0;  // one payload byte, maybe followed by a status
  localparam logic [1:0] K_FHDR = 2'd1;  // file header burst from a header slot
  localparam logic [1:0] K_THDR = 2'd2;  // tag header burst, maybe followed by a status
  localparam logic [1:0] K_STAT = 2'd3;  // status-only result, header truncated

  // Result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_HDR_SHORT  = 2'd1;
  localparam logic [1:0] STAT_BODY_SHORT = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [FILE_HDR_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       tail;  // entry ends a truncated file: status follows
  } entry_t;

  typedef struct packed {
    logic       we;
    hdr_bytes_t bytes;
  } hdr_wr_t;

endpackage

// ===== hw/rtl/flvtr_queue.sv =====
// ============================================================================
// flvtr_queue
// Small first-in first-out queue of work entries between front and back.
// ============================================================================
module flvtr_queue
  import flvtr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  entry_t              mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_QW-1:0]   count_r;
  logic                do_pop;

  assign full       = (count_r == CNT_QW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/flvtr_front.sv =====
// ============================================================================
// flvtr_front
// Accepts input bytes, tracks file and tag framing, rebases timestamps and
// turns each byte into at most one work entry for the back end.
// ============================================================================
module flvtr_front
  import flvtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  logic       in_tlast,
  input  logic       q_full,
  input  logic       slot_free,
  output logic       push,
  output entry_t     push_entry,
  output hdr_wr_t    hdr_wr
);

  logic [1:0]  stage_r, stage_e, stage_nxt;
  cnt_t        cnt_r, cnt_e, cnt_nxt;
  logic [7:0]  hold_r [HOLD_BYTES];
  logic [7:0]  hold_nxt [HOLD_BYTES];
  logic [31:0] offset_r, offset_e, offset_nxt;
  logic [31:0] last_ts_r, last_ts_e, last_ts_nxt;
  logic        failed_r, failed_e, failed_nxt;
  logic        ended_r, ended_e, ended_nxt;
  logic [31:0] ts_sum;
  logic        accept;
  logic        emit;
  entry_t      entry;
  hdr_wr_t     wr;
  logic        file_start;
  logic        first_file;

  assign file_start = in_tuser[0];
  assign first_file = in_tuser[1];
  assign in_tready  = !q_full && slot_free;
  assign accept     = in_tvalid && in_tready;
  assign push       = accept && emit;
  assign push_entry = entry;
  assign hdr_wr.we    = accept && wr.we;
  assign hdr_wr.bytes = wr.bytes;

  // Rebased timestamp of the tag header being held
  assign ts_sum = {hold_r[7], hold_r[4], hold_r[5], hold_r[6]} + offset_e;

  // Classify the byte and compute next state
  always_comb begin
    stage_e   = stage_r;
    cnt_e     = cnt_r;
    failed_e  = failed_r;
    ended_e   = ended_r;
    offset_e  = offset_r;
    last_ts_e = last_ts_r;
    if (file_start) begin
      if (first_file) begin
        failed_e = 1'b0;
        offset_e = '0;
      end
      last_ts_e = '0;
      ended_e   = 1'b0;
      cnt_e     = '0;
      stage_e   = first_file ? STG_HDR_KEEP : STG_HDR_SKIP;
    end

    stage_nxt   = stage_e;
    cnt_nxt     = cnt_e;
    failed_nxt  = failed_e;
    ended_nxt   = ended_e;
    offset_nxt  = offset_e;
    last_ts_nxt = last_ts_e;
    for (int i = 0; i < HOLD_BYTES; i++) begin
      hold_nxt[i] = hold_r[i];
      wr.bytes[i] = hold_r[i];
    end
    wr.bytes[FILE_HDR_BYTES-1] = in_tdata;
    wr.we      = 1'b0;
    emit       = 1'b0;
    entry.kind = K_BYTE;
    entry.data = in_tdata;
    entry.tail = 1'b0;

    if (!(failed_e || ended_e)) begin
      case (stage_e)
        STG_HDR_KEEP, STG_HDR_SKIP: begin
          if (cnt_e < CNT_W'(FILE_HDR_BYTES - 1)) begin
            if (stage_e == STG_HDR_KEEP) begin
              hold_nxt[cnt_e[IDX_W-1:0]] = in_tdata;
            end
            cnt_nxt = cnt_e + 1'b1;
          end else begin
            if (stage_e == STG_HDR_KEEP) begin
              wr.we      = 1'b1;
              emit       = 1'b1;
              entry.kind = K_FHDR;
            end
            stage_nxt = STG_TAG_HDR;
            cnt_nxt   = '0;
          end
        end
        STG_TAG_HDR: begin
          if (cnt_e < CNT_W'(TAG_HDR_BYTES - 1)) begin
            hold_nxt[cnt_e[IDX_W-1:0]] = in_tdata;
            cnt_nxt = cnt_e + 1'b1;
          end else begin
            wr.we = 1'b1;
            wr.bytes[4] = ts_sum[23:16];
            wr.bytes[5] = ts_sum[15:8];
            wr.bytes[6] = ts_sum[7:0];
            wr.bytes[7] = ts_sum[31:24];
            wr.bytes[TAG_HDR_BYTES-1] = in_tdata;
            emit        = 1'b1;
            entry.kind  = K_THDR;
            last_ts_nxt = ts_sum;
            stage_nxt   = STG_PAYLOAD;
            cnt_nxt     = {1'b0, hold_r[1], hold_r[2], hold_r[3]} + CNT_W'(TRAILER_BYTES);
          end
        end
        default: begin
          emit    = 1'b1;
          cnt_nxt = cnt_e - 1'b1;
          if (cnt_e == CNT_W'(1)) begin
            stage_nxt = STG_TAG_HDR;
          end
        end
      endcase

      // Close the file: flag truncation or take the last timestamp as offset
      if (in_tlast) begin
        ended_nxt = 1'b1;
        if (stage_nxt == STG_HDR_KEEP) begin
          failed_nxt = 1'b1;
          emit       = 1'b1;
          entry.kind = K_STAT;
          entry.data = '0;
        end else if (stage_nxt == STG_PAYLOAD) begin
          failed_nxt = 1'b1;
          entry.tail = 1'b1;
        end else begin
          offset_nxt = last_ts_nxt;
        end
      end
    end
  end

  // Hold header bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HOLD_BYTES; i++) begin
        hold_r[i] <= hold_nxt[i];
      end
    end
  end

  // Update framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= STG_HDR_KEEP;
      cnt_r     <= '0;
      offset_r  <= '0;
      last_ts_r <= '0;
      failed_r  <= 1'b0;
      ended_r   <= 1'b0;
    end else if (accept) begin
      stage_r   <= stage_nxt;
      cnt_r     <= cnt_nxt;
      offset_r  <= offset_nxt;
      last_ts_r <= last_ts_nxt;
      failed_r  <= failed_nxt;
      ended_r   <= ended_nxt;
    end
  end

endmodule

// ===== hw/rtl/flvtr_back.sv =====
// ============================================================================
// flvtr_back
// Drains work entries into result items: header bursts from two header
// slots, payload bytes and status results, through an output register.
// ============================================================================
module flvtr_back
  import flvtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hdr_wr_t    hdr_wr,
  output logic       slot_free,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [2:0] out_tuser,
  output logic       out_tlast
);

  hdr_bytes_t       slot_r [2];
  logic [1:0]       busy_r;
  logic             swr_r;
  logic             srd_r;
  logic [IDX_W-1:0] idx_r;
  logic             valid_r;
  logic [7:0]       data_r;
  logic             bv_r;
  logic [1:0]       stat_r;
  logic             last_r;
  logic             adv;
  logic             take;
  logic [7:0]       res_data;
  logic             res_bv;
  logic [1:0]       res_stat;
  logic             res_last;
  logic             burst;

  assign slot_free  = !busy_r[swr_r];
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = {stat_r, bv_r};
  assign out_tlast  = last_r;
  assign adv        = !valid_r || out_tready;
  assign take       = head_valid && adv;
  assign pop        = take && res_last;
  assign burst      = (head_entry.kind == K_FHDR) || (head_entry.kind == K_THDR);

  // Form the next result of the head entry
  always_comb begin
    res_data = slot_r[srd_r][idx_r];
    res_bv   = 1'b1;
    res_stat = STAT_OK;
    res_last = 1'b0;
    case (head_entry.kind)
      K_BYTE: begin
        if (idx_r == '0) begin
          res_data = head_entry.data;
          res_last = !head_entry.tail;
        end else begin
          res_data = '0;
          res_bv   = 1'b0;
          res_stat = STAT_BODY_SHORT;
          res_last = 1'b1;
        end
      end
      K_FHDR: res_last = (idx_r == IDX_W'(FILE_HDR_BYTES - 1));
      K_THDR: begin
        // Append the truncation status after a header that ends its file
        if (idx_r == IDX_W'(TAG_HDR_BYTES)) begin
          res_data = '0;
          res_bv   = 1'b0;
          res_stat = STAT_BODY_SHORT;
          res_last = 1'b1;
        end else begin
          res_last = (idx_r == IDX_W'(TAG_HDR_BYTES - 1)) && !head_entry.tail;
        end
      end
      default: begin
        res_data = '0;
        res_bv   = 1'b0;
        res_stat = STAT_HDR_SHORT;
        res_last = 1'b1;
      end
    endcase
  end

  // Write finished headers into the free slot
  always_ff @(posedge clk) begin
    if (hdr_wr.we) begin
      slot_r[swr_r] <= hdr_wr.bytes;
    end
  end

  // Track slot ownership, burst position and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      swr_r   <= 1'b0;
      srd_r   <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (hdr_wr.we) begin
        busy_r[swr_r] <= 1'b1;
        swr_r         <= !swr_r;
      end
      if (take) begin
        valid_r <= 1'b1;
        if (res_last) begin
          idx_r <= '0;
          if (burst) begin
            busy_r[srd_r] <= 1'b0;
            srd_r         <= !srd_r;
          end
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (adv) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= res_data;
      bv_r   <= res_bv;
      stat_r <= res_stat;
      last_r <= res_last;
    end
  end

endmodule

// ===== hw/rtl/flv_tag_timestamp_rebase_unit.sv =====
// ============================================================================
// flv_tag_timestamp_rebase_unit
// Merges successive FLV files into one stream with rebased tag timestamps.
// ============================================================================
// The unit takes one input byte per clock. Tag headers and the first file's
// header are held until complete, then sent as a burst of 11 or 13 result
// items, one per clock, from one of two header slots; payload bytes pass
// through one per clock. A queue of QUEUE_DEPTH entries (default 16) sits
// between the byte classifier and the result generator, so the input keeps
// flowing while a header burst is being sent. in_tready drops when that
// queue is full or when both header slots still hold unsent headers. A
// result passes through the queue and the output register. A truncated
// first-file header or cut payload is reported with a status-only item
// (tuser byte_valid low), then input is dropped until the next first file.
// ============================================================================
module flv_tag_timestamp_rebase_unit
  import flvtr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [0] file_start, [1] first_file
  input  logic       in_tlast,   // file_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] byte_valid, [2:1] status
  output logic       out_tlast   // run_end
);

  logic    q_full;
  logic    slot_free;
  logic    push;
  entry_t  push_entry;
  hdr_wr_t hdr_wr;
  logic    pop;
  logic    head_valid;
  entry_t  head_entry;

  flvtr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .slot_free  (slot_free),
    .push       (push),
    .push_entry (push_entry),
    .hdr_wr     (hdr_wr)
  );

  flvtr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  flvtr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .hdr_wr     (hdr_wr),
    .slot_free  (slot_free),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/sv/flv_tag_timestamp_rebase_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// flv_tag_timestamp_rebase_unit_tb
// Self-checking bench for the FLV tag timestamp rebase unit. A queue of FLV
// file bytes (clean files, short headers, partial tag headers, cut payloads,
// abandoned files and stray bytes) feeds a stream driver. Each accepted byte
// runs through a bench-side model of the merge and rebase, whose output items
// are compared field by field with what the unit sends. Both sides idle at
// random, the receiver holds off once for a long stretch, and the sender
// waits for the output to drain at marked points.
// ============================================================================
module flv_tag_timestamp_rebase_unit_tb;
  import flvtr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  // One input byte, or a marker that makes the sender wait for the output
  typedef struct {
    logic [7:0] data;
    bit         fstart;
    bit         ffirst;
    bit         fend;
    bit         pause;
  } file_byte_t;

  // One merged stream item as the unit should send it
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic [1:0] status;
    logic       run_end;
  } merged_item_t;

  typedef enum int {
    END_CLEAN,
    END_SHORT_HDR,
    END_PART_TAG,
    END_CUT_BODY,
    END_OPEN
  } file_end_e;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic [1:0] in_tuser   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  file_byte_t   file_bytes[$];
  merged_item_t expected_stream[$];

  bit  in_taken   = 1'b0;
  int  in_count   = 0;
  int  err_cnt    = 0;
  int  cycle_cnt  = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  wire calm       = (in_count >= 90) && (in_count < 190);

  // Merge model state
  logic [1:0]  front_stage = STG_HDR_KEEP;
  cnt_t        held_cnt    = '0;
  logic [7:0]  hdr_hold[HOLD_BYTES];
  logic [31:0] ts_offset   = '0;
  logic [31:0] last_ts     = '0;
  bit          dropping    = 1'b0;
  bit          file_closed = 1'b0;

  flv_tag_timestamp_rebase_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the merge model by one byte and queue the items it sends
  task automatic rebase_byte(input logic [7:0] b, input bit fs, input bit ff, input bit fe);
    merged_item_t res[$];
    logic [7:0]   th[TAG_HDR_BYTES];
    logic [31:0]  ts;
    cnt_t         size;
    if (fs) begin
      if (ff) begin
        dropping  = 1'b0;
        ts_offset = '0;
      end
      last_ts     = '0;
      file_closed = 1'b0;
      held_cnt    = '0;
      front_stage = ff ? STG_HDR_KEEP : STG_HDR_SKIP;
    end
    if (!(dropping || file_closed)) begin
      case (front_stage)
        STG_HDR_KEEP, STG_HDR_SKIP: begin
          if (held_cnt + 1 < FILE_HDR_BYTES) begin
            if (front_stage == STG_HDR_KEEP) hdr_hold[held_cnt] = b;
            held_cnt++;
          end else begin
            if (front_stage == STG_HDR_KEEP) begin
              for (int i = 0; i < HOLD_BYTES; i++)
                res.push_back('{hdr_hold[i], 1'b1, STAT_OK, 1'b0});
              res.push_back('{b, 1'b1, STAT_OK, 1'b0});
            end
            front_stage = STG_TAG_HDR;
            held_cnt    = '0;
          end
        end
        STG_TAG_HDR: begin
          if (held_cnt + 1 < TAG_HDR_BYTES) begin
            hdr_hold[held_cnt] = b;
            held_cnt++;
          end else begin
            for (int i = 0; i < TAG_HDR_BYTES - 1; i++) th[i] = hdr_hold[i];
            th[TAG_HDR_BYTES-1] = b;
            size  = cnt_t'({th[1], th[2], th[3]});
            // low 24 bits big-endian in bytes 4-6, high byte in byte 7
            ts    = {th[7], th[4], th[5], th[6]} + ts_offset;
            th[7] = ts[31:24];
            th[4] = ts[23:16];
            th[5] = ts[15:8];
            th[6] = ts[7:0];
            last_ts = ts;
            for (int i = 0; i < TAG_HDR_BYTES; i++)
              res.push_back('{th[i], 1'b1, STAT_OK, 1'b0});
            front_stage = STG_PAYLOAD;
            held_cnt    = cnt_t'(size + TRAILER_BYTES);
          end
        end
        default: begin
          res.push_back('{b, 1'b1, STAT_OK, 1'b0});
          if (held_cnt != 0) held_cnt--;
          if (held_cnt == 0) front_stage = STG_TAG_HDR;
        end
      endcase
      // Close the file: truncations fail the run, clean ends carry the offset
      if (fe) begin
        file_closed = 1'b1;
        if (front_stage == STG_HDR_KEEP) begin
          dropping = 1'b1;
          res.push_back('{8'h00, 1'b0, STAT_HDR_SHORT, 1'b0});
        end else if (front_stage == STG_PAYLOAD) begin
          dropping = 1'b1;
          res.push_back('{8'h00, 1'b0, STAT_BODY_SHORT, 1'b0});
        end else begin
          ts_offset = last_ts;
        end
      end
    end
    if (res.size() != 0) res[res.size()-1].run_end = 1'b1;
    foreach (res[i]) expected_stream.push_back(res[i]);
  endtask

  task automatic push_byte(input logic [7:0] d, input bit fs, input bit ff, input bit fe);
    file_byte_t fb;
    fb = '{d, fs, ff, fe, 1'b0};
    file_bytes.push_back(fb);
  endtask

  task automatic push_pause();
    file_byte_t fb;
    fb = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
    file_bytes.push_back(fb);
  endtask

  // Build one input file with the given number of tags and kind of ending
  task automatic add_file(input bit first, input int tags, input file_end_e how);
    logic [7:0]  body[$];
    logic [23:0] size;
    logic [31:0] ts;
    int          k;
    bit          cut_tag;
    if (how == END_SHORT_HDR) begin
      k = $urandom_range(1, FILE_HDR_BYTES - 1);
      repeat (k) body.push_back(8'($urandom));
    end else begin
      repeat (FILE_HDR_BYTES) body.push_back(8'($urandom));
      for (int t = 0; t < tags; t++) begin
        cut_tag = (how == END_CUT_BODY) && (t == tags - 1);
        // large sizes only where the payload gets cut short
        if (cut_tag && $urandom_range(0, 2) == 0) size = 24'($urandom);
        else size = 24'($urandom_range(0, 9));
        case ($urandom_range(0, 3))
          0:       ts = '0;
          1:       ts = '1;
          default: ts = $urandom;
        endcase
        body.push_back(8'($urandom));
        body.push_back(size[23:16]);
        body.push_back(size[15:8]);
        body.push_back(size[7:0]);
        body.push_back(ts[23:16]);
        body.push_back(ts[15:8]);
        body.push_back(ts[7:0]);
        body.push_back(ts[31:24]);
        repeat (3) body.push_back(8'($urandom));
        if (!cut_tag) k = size + TRAILER_BYTES;
        else if (size > 9) k = $urandom_range(0, 6);
        else k = $urandom_range(0, size + TRAILER_BYTES - 1);
        repeat (k) body.push_back(8'($urandom));
      end
      if (how == END_PART_TAG)
        repeat ($urandom_range(1, TAG_HDR_BYTES - 1)) body.push_back(8'($urandom));
    end
    foreach (body[i])
      push_byte(body[i], i == 0, (i == 0) ? first : 1'($urandom),
                how != END_OPEN && i == body.size() - 1);
    // stray bytes between files
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0, 1'($urandom), 1'($urandom));
  endtask

  task automatic check_field(input string label, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Take input items and run them through the model
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      rebase_byte(in_tdata, in_tuser[0], in_tuser[1], in_tlast);
      in_taken = 1'b1;
      in_count++;
    end
  end

  // Drive the next byte once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (file_bytes.size() == 0 || (!calm && $urandom_range(0, 99) < 27)) begin
        in_tvalid <= 1'b0;
      end else if (file_bytes[0].pause) begin
        in_tvalid <= 1'b0;
        if (expected_stream.size() == 0) void'(file_bytes.pop_front());
      end else begin
        in_tdata  <= file_bytes[0].data;
        in_tuser  <= {file_bytes[0].ffirst, file_bytes[0].fstart};
        in_tlast  <= file_bytes[0].fend;
        in_tvalid <= 1'b1;
        void'(file_bytes.pop_front());
      end
    end
  end

  // Count down the long receiver hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count >= 130) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Stall the output at random
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 27);
  end

  // Compare each output item with the oldest expected one
  always @(posedge clk) begin
    merged_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_stream.size() == 0) begin
        err_cnt++;
        $display("%0t: item with none expected: actual byte %0h tuser %0h last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_stream.pop_front();
        check_field("out_byte", want.data, out_tdata);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_tuser[0]));
        check_field("status", 8'(want.status), 8'(out_tuser[2:1]));
        check_field("run_end", 8'(want.run_end), 8'(out_tlast));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    bit        need_first;
    bit        first;
    int        r;
    int        tags;
    file_end_e how;

    // Bytes before any file start, cut short: header truncated
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b0, 1'b1);
    // Dropped: after the end, then a later file while failed
    push_byte(8'hA5, 1'b0, 1'b1, 1'b0);
    push_byte(8'h3C, 1'b1, 1'b0, 1'b1);
    push_pause();

    // Mostly well-formed files with random content and endings
    need_first = 1'b1;
    do begin
      first = need_first ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 6) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) how = END_CLEAN;
      else if (r < 55) how = END_SHORT_HDR;
      else if (r < 70) how = END_PART_TAG;
      else if (r < 85) how = END_CUT_BODY;
      else how = END_OPEN;
      tags = $urandom_range((how == END_CUT_BODY) ? 1 : 0, 3);
      add_file(first, tags, how);
      if (first || !need_first)
        need_first = (how == END_CUT_BODY) || (first && how == END_SHORT_HDR);
      if ($urandom_range(0, 9) == 0) push_pause();
    end while (file_bytes.size() < 185);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain input, then output, then allow for late extra items
    while (file_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_stream.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
